@@ hw/rtl/fpd_pkg.sv @@
// Shared types and constants for the fingerprint packet deframer.
`timescale 1ns / 1ps
`default_nettype none
package fpd_pkg;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_GOOD    = 2'd1;
  localparam logic [1:0] KIND_BAD_SUM = 2'd2;
  localparam logic [1:0] KIND_BAD_LEN = 2'd3;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER_FIRST   = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER_SECOND  = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDRESS = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_LENGTH     = 8'd3;

  localparam logic [7:0]  RESET_HEADER_FIRST   = 8'd239;
  localparam logic [7:0]  RESET_HEADER_SECOND  = 8'd1;
  localparam logic [31:0] RESET_DEVICE_ADDRESS = 32'hFFFF_FFFF;
  localparam logic [15:0] RESET_MAX_LENGTH     = 16'd256;

  localparam logic [15:0] CHECKSUM_BYTES = 16'd2;

  typedef enum logic [11:0] {
    PH_HDR0    = 12'b0000_0000_0001,
    PH_HDR1    = 12'b0000_0000_0010,
    PH_ADDR0   = 12'b0000_0000_0100,
    PH_ADDR1   = 12'b0000_0000_1000,
    PH_ADDR2   = 12'b0000_0001_0000,
    PH_ADDR3   = 12'b0000_0010_0000,
    PH_TYPE    = 12'b0000_0100_0000,
    PH_LEN_HI  = 12'b0000_1000_0000,
    PH_LEN_LO  = 12'b0001_0000_0000,
    PH_PAYLOAD = 12'b0010_0000_0000,
    PH_CSUM_HI = 12'b0100_0000_0000,
    PH_CSUM_LO = 12'b1000_0000_0000
  } phase_t;

  typedef struct packed {
    logic [7:0]  header_first;
    logic [7:0]  header_second;
    logic [31:0] device_address;
    logic [15:0] max_length;
  } cfg_t;

  typedef struct packed {
    logic [15:0] frame_length;
    logic [7:0]  byte_value;
    logic [7:0]  packet_type;
    logic [1:0]  kind;
  } res_t;

endpackage
`default_nettype wire

@@ hw/rtl/fingerprint_packet_deframer.sv @@
// Top level of the fingerprint packet deframer: stream ports, registers and pipeline.
// Path: a byte is held in the input register, then any result in the result register.
// Throughput: one byte per cycle while the output side keeps taking results; the rate
// is set by the single parser step between the input register and the result register.
// Reset: rst is synchronous and active high; it restores the register defaults, empties
// both pipeline registers and returns the parser to the first header byte.
`timescale 1ns / 1ps
`default_nettype none
module fingerprint_packet_deframer (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [7:0]                      s_tdata,   // rx_byte[7:0]
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // kind[1:0], packet_type[9:2], byte_value[17:10], frame_length[33:18], zero[39:34]
  output logic [39:0]                          m_tdata,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [fpd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [31:0]                     cfg_data
);

  fpd_pkg::cfg_t cfg;
  logic          in_valid;
  logic [7:0]    in_byte;
  logic          advance;
  logic          res_fire;
  fpd_pkg::res_t res;
  fpd_pkg::res_t out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_first   <= fpd_pkg::RESET_HEADER_FIRST;
      cfg.header_second  <= fpd_pkg::RESET_HEADER_SECOND;
      cfg.device_address <= fpd_pkg::RESET_DEVICE_ADDRESS;
      cfg.max_length     <= fpd_pkg::RESET_MAX_LENGTH;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fpd_pkg::REG_HEADER_FIRST:   cfg.header_first   <= cfg_data[7:0];
        fpd_pkg::REG_HEADER_SECOND:  cfg.header_second  <= cfg_data[7:0];
        fpd_pkg::REG_DEVICE_ADDRESS: cfg.device_address <= cfg_data;
        fpd_pkg::REG_MAX_LENGTH:     cfg.max_length     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // The held byte moves through the parser when the result register is free or draining.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  fpd_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .rx_byte  (in_byte),
    .cfg      (cfg),
    .res_fire (res_fire),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= res_fire;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_fire) begin
      out_res <= res;
    end
  end

  assign m_tdata = {6'd0, out_res};

`ifndef ASSERT_OFF
  a_zero_byte_on_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] != fpd_pkg::KIND_PAYLOAD) |-> m_tdata[17:10] == 8'd0)
    else $error("status result carries a nonzero byte value");

  a_input_held: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_byte))
    else $error("held input byte lost or changed while stalled");

  a_result_registered: assert property (@(posedge clk) disable iff (rst)
    advance && res_fire |=> m_tvalid && (m_tdata[33:0] == $past(res)))
    else $error("parser result not captured in the output register");

  a_no_advance_on_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !advance)
    else $error("parser stepped while the output register was blocked");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/fpd_parser.sv @@
// Packet parser state machine: consumes one byte per step and produces at most one result.
`timescale 1ns / 1ps
`default_nettype none
module fpd_parser (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire logic [7:0]    rx_byte,
  input  wire fpd_pkg::cfg_t cfg,
  output logic               res_fire,
  output fpd_pkg::res_t      res
);

  fpd_pkg::phase_t phase, phase_next;
  logic [7:0]  current_type, current_type_next;
  logic [15:0] declared_length, declared_length_next;
  logic [15:0] bytes_remaining, bytes_remaining_next;
  logic [15:0] running_sum, running_sum_next;
  logic [7:0]  checksum_high, checksum_high_next;

  logic        do_clear;
  logic [15:0] sum_add;
  logic [15:0] len_full;

  assign sum_add  = running_sum + {8'd0, rx_byte};
  assign len_full = {declared_length[15:8], rx_byte};

  always_comb begin
    phase_next           = phase;
    current_type_next    = current_type;
    declared_length_next = declared_length;
    bytes_remaining_next = bytes_remaining;
    running_sum_next     = running_sum;
    checksum_high_next   = checksum_high;
    do_clear             = 1'b0;
    res_fire             = 1'b0;
    res.kind             = fpd_pkg::KIND_PAYLOAD;
    res.packet_type      = current_type;
    res.byte_value       = 8'd0;
    res.frame_length     = declared_length;

    case (phase)
      fpd_pkg::PH_HDR1: begin
        if (rx_byte == cfg.header_second) phase_next = fpd_pkg::PH_ADDR0;
        else do_clear = 1'b1;
      end
      fpd_pkg::PH_ADDR0: begin
        if (rx_byte == cfg.device_address[31:24]) phase_next = fpd_pkg::PH_ADDR1;
        else do_clear = 1'b1;
      end
      fpd_pkg::PH_ADDR1: begin
        if (rx_byte == cfg.device_address[23:16]) phase_next = fpd_pkg::PH_ADDR2;
        else do_clear = 1'b1;
      end
      fpd_pkg::PH_ADDR2: begin
        if (rx_byte == cfg.device_address[15:8]) phase_next = fpd_pkg::PH_ADDR3;
        else do_clear = 1'b1;
      end
      fpd_pkg::PH_ADDR3: begin
        if (rx_byte == cfg.device_address[7:0]) phase_next = fpd_pkg::PH_TYPE;
        else do_clear = 1'b1;
      end
      fpd_pkg::PH_TYPE: begin
        current_type_next = rx_byte;
        running_sum_next  = {8'd0, rx_byte};
        phase_next        = fpd_pkg::PH_LEN_HI;
      end
      fpd_pkg::PH_LEN_HI: begin
        declared_length_next = {rx_byte, 8'd0};
        running_sum_next     = sum_add;
        phase_next           = fpd_pkg::PH_LEN_LO;
      end
      fpd_pkg::PH_LEN_LO: begin
        declared_length_next = len_full;
        running_sum_next     = sum_add;
        if (len_full < fpd_pkg::CHECKSUM_BYTES || len_full > cfg.max_length) begin
          res_fire         = 1'b1;
          res.kind         = fpd_pkg::KIND_BAD_LEN;
          res.frame_length = len_full;
          do_clear         = 1'b1;
        end else begin
          bytes_remaining_next = len_full - fpd_pkg::CHECKSUM_BYTES;
          phase_next = (len_full == fpd_pkg::CHECKSUM_BYTES) ? fpd_pkg::PH_CSUM_HI
                                                             : fpd_pkg::PH_PAYLOAD;
        end
      end
      fpd_pkg::PH_PAYLOAD: begin
        running_sum_next     = sum_add;
        bytes_remaining_next = bytes_remaining - 16'd1;
        if (bytes_remaining == 16'd1) phase_next = fpd_pkg::PH_CSUM_HI;
        res_fire       = 1'b1;
        res.byte_value = rx_byte;
      end
      fpd_pkg::PH_CSUM_HI: begin
        checksum_high_next = rx_byte;
        phase_next         = fpd_pkg::PH_CSUM_LO;
      end
      fpd_pkg::PH_CSUM_LO: begin
        res_fire = 1'b1;
        res.kind = ({checksum_high, rx_byte} == running_sum) ? fpd_pkg::KIND_GOOD
                                                             : fpd_pkg::KIND_BAD_SUM;
        do_clear = 1'b1;
      end
      default: begin
        // First header byte; any stray code also lands here.
        if (rx_byte == cfg.header_first) phase_next = fpd_pkg::PH_HDR1;
        else do_clear = 1'b1;
      end
    endcase

    if (do_clear) begin
      phase_next           = fpd_pkg::PH_HDR0;
      current_type_next    = 8'd0;
      declared_length_next = 16'd0;
      bytes_remaining_next = 16'd0;
      running_sum_next     = 16'd0;
      checksum_high_next   = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= fpd_pkg::PH_HDR0;
      current_type    <= 8'd0;
      declared_length <= 16'd0;
      bytes_remaining <= 16'd0;
      running_sum     <= 16'd0;
      checksum_high   <= 8'd0;
    end else if (step) begin
      phase           <= phase_next;
      current_type    <= current_type_next;
      declared_length <= declared_length_next;
      bytes_remaining <= bytes_remaining_next;
      running_sum     <= running_sum_next;
      checksum_high   <= checksum_high_next;
    end
  end

endmodule
`default_nettype wire
